// ===== rtl/core/tms_pkg.sv =====
// Shared types and constants of the triangle-strip mesh index sequencer.
package tms_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_QUAD_COLUMNS  = 3'd0;
  localparam logic [2:0] CFG_QUAD_ROWS     = 3'd1;
  localparam logic [2:0] CFG_TAP_FIRST     = 3'd2;
  localparam logic [2:0] CFG_TAP_LAST      = 3'd3;
  localparam logic [2:0] CFG_BASE_VERTEX   = 3'd4;
  localparam logic [2:0] CFG_ROW_STRIDE    = 3'd5;
  localparam logic [2:0] CFG_COLUMN_STRIDE = 3'd6;

  // Emit phases, one-hot
  typedef enum logic [6:0] {
    PH_ENTRY    = 7'b0000001,
    PH_HEAD     = 7'b0000010,
    PH_PRIME    = 7'b0000100,
    PH_ROWSTART = 7'b0001000,
    PH_PAIRS    = 7'b0010000,
    PH_ROWEND   = 7'b0100000,
    PH_LAST     = 7'b1000000
  } phase_t;

  // Configuration as seen by the sequencer, with the effective strides
  typedef struct packed {
    logic [7:0]  quad_columns;
    logic [7:0]  quad_rows;
    logic        tap_first;
    logic        tap_last;
    logic [15:0] base_vertex;
    logic [15:0] row_step;
    logic [15:0] col_step;
  } cfg_t;

endpackage

// ===== rtl/core/tristrip_mesh_index_sequencer.sv =====
// Top level of the triangle-strip mesh index sequencer.
//
// Usage: each item accepted on the in_ channel (in_valid & in_ready) yields
// exactly one result item on the out_ channel: the next vertex index of a
// single triangle strip over the configured quad grid, and out_strip_end
// on the last index of the strip. in_restart = 1 restarts the strip and the
// result is its first index. Grids wider than STACK_COLUMNS are emitted as
// stacks joined by degenerate double taps.
// A result sits in the output register in the cycle after its item is
// accepted. Throughput: one item per cycle unless the output stalls; the
// next state, its running sums and one stack-origin multiply are combinational.
// Stall: while the receiver holds out_ready low the result is held and
// in_ready drops, so no result is lost; in_ready returns as the result
// leaves, in the same cycle.
// Configuration: cfg_ writes are always taken (cfg_ready = 1); write only
// while no result is pending. Reset (rst_n low, synchronous) restores the
// register defaults and places the sequencer at the start of the strip.
module tristrip_mesh_index_sequencer
  import tms_pkg::*;
#(
  parameter int STACK_COLUMNS = 14,
  parameter int INDEX_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_vertex_index,
  output logic        out_strip_end
);

  localparam int WW = $clog2(STACK_COLUMNS + 1);
  localparam int IB = INDEX_BITS;

  cfg_t cfg;
  logic in_fire;
  logic can_load;

  // Sequencer state
  logic [7:0]    sfc_r, sfc_nxt;
  logic [WW-1:0] sw_r, sw_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    rc_r, rc_nxt;
  logic [WW-1:0] cc_r, cc_nxt;
  logic          half_r, half_nxt;
  logic [IB-1:0] rbs_r, rbs_nxt;
  logic [IB-1:0] cos_r, cos_nxt;

  // Step results
  logic [IB-1:0] idx;
  logic          wrapped;
  logic [7:0]    left;
  logic          is_last;
  logic [23:0]   origin_prod;
  logic [IB-1:0] h_ext, v_ext;
  logic          entry_tap;
  logic          rows_beg, tail, endst;

  tms_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_ready = can_load;
  assign in_fire  = in_valid && in_ready;
  assign h_ext    = IB'(cfg.col_step);
  assign v_ext    = IB'(cfg.row_step);

  // Compute one strip step from the current state
  always_comb begin
    sfc_nxt   = sfc_r;
    sw_nxt    = sw_r;
    phase_nxt = phase_r;
    rc_nxt    = rc_r;
    cc_nxt    = cc_r;
    half_nxt  = half_r;
    rbs_nxt   = rbs_r;
    cos_nxt   = cos_r;
    idx       = '0;
    wrapped   = 1'b0;
    entry_tap = 1'b0;
    rows_beg  = 1'b0;
    tail      = 1'b0;
    endst     = 1'b0;

    // Restart drops back to the first stack
    if (in_restart) begin
      sfc_nxt   = 8'd0;
      phase_nxt = PH_ENTRY;
      rc_nxt    = 8'd0;
      cc_nxt    = '0;
      half_nxt  = 1'b0;
    end

    // Any code that is not a phase reenters the stack
    unique case (phase_nxt)
      PH_HEAD, PH_PRIME, PH_ROWSTART, PH_PAIRS, PH_ROWEND, PH_LAST: ;
      default: phase_nxt = PH_ENTRY;
    endcase

    // Columns left from this stack on
    left    = (cfg.quad_columns > sfc_nxt) ? (cfg.quad_columns - sfc_nxt) : 8'd0;
    is_last = ({1'b0, left} <= 9'(STACK_COLUMNS));
    origin_prod = {16'd0, sfc_nxt} * {8'd0, cfg.col_step};

    // Enter the stack: width, origin, optional first tap
    if (phase_nxt == PH_ENTRY) begin
      sw_nxt    = ({1'b0, left} > 9'(STACK_COLUMNS)) ? WW'(STACK_COLUMNS) : WW'(left);
      rbs_nxt   = IB'(cfg.base_vertex) + IB'(origin_prod);
      cos_nxt   = '0;
      rc_nxt    = 8'd0;
      cc_nxt    = '0;
      half_nxt  = 1'b0;
      phase_nxt = PH_HEAD;
      if (sfc_nxt != 8'd0 || cfg.tap_first) begin
        entry_tap = 1'b1;
        idx       = rbs_nxt;
      end
    end

    if (!entry_tap) begin
      unique case (phase_nxt)
        PH_HEAD: begin
          idx = rbs_nxt;
          if (sw_nxt != '0) begin
            phase_nxt = PH_PRIME;
            cc_nxt    = WW'(1);
            cos_nxt   = h_ext;
            half_nxt  = 1'b0;
          end else begin
            cos_nxt  = '0;
            rows_beg = 1'b1;
          end
        end
        PH_PRIME: begin
          idx = rbs_nxt + cos_nxt;
          if (!half_nxt) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            if (cc_nxt < sw_nxt) begin
              cc_nxt  = cc_nxt + WW'(1);
              cos_nxt = cos_nxt + h_ext;
            end else begin
              rows_beg = 1'b1;
            end
          end
        end
        PH_ROWSTART: begin
          idx       = rbs_nxt;
          phase_nxt = PH_PAIRS;
          cc_nxt    = '0;
          cos_nxt   = '0;
          half_nxt  = 1'b0;
        end
        PH_PAIRS: begin
          idx = rbs_nxt + cos_nxt + (half_nxt ? v_ext : '0);
          if (!half_nxt) begin
            half_nxt = 1'b1;
          end else begin
            half_nxt = 1'b0;
            if (cc_nxt < sw_nxt) begin
              cc_nxt  = cc_nxt + WW'(1);
              cos_nxt = cos_nxt + h_ext;
            end else if (({1'b0, rc_nxt} + 9'd1) < {1'b0, cfg.quad_rows}) begin
              phase_nxt = PH_ROWEND;
            end else begin
              rbs_nxt = rbs_nxt + v_ext;
              rc_nxt  = rc_nxt + 8'd1;
              tail    = 1'b1;
            end
          end
        end
        PH_ROWEND: begin
          idx       = rbs_nxt + v_ext + cos_nxt;
          rbs_nxt   = rbs_nxt + v_ext;
          rc_nxt    = rc_nxt + 8'd1;
          phase_nxt = PH_ROWSTART;
        end
        default: begin
          idx   = rbs_nxt + cos_nxt;
          endst = 1'b1;
        end
      endcase
    end

    // Begin the rows, or close the stack when there are none
    if (rows_beg) begin
      rc_nxt = 8'd0;
      if (cfg.quad_rows != 8'd0) begin
        phase_nxt = PH_ROWSTART;
      end else begin
        tail = 1'b1;
      end
    end

    // Add the final tap where one is due
    if (tail) begin
      if (!is_last || cfg.tap_last) begin
        phase_nxt = PH_LAST;
      end else begin
        endst = 1'b1;
      end
    end

    // Advance to the next stack, or wrap to the first
    if (endst) begin
      if (is_last) begin
        sfc_nxt = 8'd0;
        wrapped = 1'b1;
      end else begin
        sfc_nxt = 8'({1'b0, sfc_nxt} + 9'(STACK_COLUMNS));
      end
      phase_nxt = PH_ENTRY;
      rc_nxt    = 8'd0;
      cc_nxt    = '0;
      half_nxt  = 1'b0;
    end
  end

  // Hold state until an item is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sfc_r   <= 8'd0;
      sw_r    <= '0;
      phase_r <= PH_ENTRY;
      rc_r    <= 8'd0;
      cc_r    <= '0;
      half_r  <= 1'b0;
      rbs_r   <= '0;
      cos_r   <= '0;
    end else if (in_fire) begin
      sfc_r   <= sfc_nxt;
      sw_r    <= sw_nxt;
      phase_r <= phase_nxt;
      rc_r    <= rc_nxt;
      cc_r    <= cc_nxt;
      half_r  <= half_nxt;
      rbs_r   <= rbs_nxt;
      cos_r   <= cos_nxt;
    end
  end

  tms_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_fire),
    .vertex_in        (16'(idx)),
    .end_in           (wrapped),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_index (out_vertex_index),
    .out_strip_end    (out_strip_end)
  );

endmodule

// ===== rtl/core/tms_cfg_regs.sv =====
// Configuration register file with effective stride derivation.
module tms_cfg_regs
  import tms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  logic [7:0]  quad_columns_r;
  logic [7:0]  quad_rows_r;
  logic        tap_first_r;
  logic        tap_last_r;
  logic [15:0] base_vertex_r;
  logic [15:0] row_stride_r;
  logic [15:0] column_stride_r;
  logic [8:0]  cols_plus_one;

  // Always take writes
  assign cfg_ready = 1'b1;

  // Write the addressed register, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_columns_r  <= 8'd1;
      quad_rows_r     <= 8'd1;
      tap_first_r     <= 1'b0;
      tap_last_r      <= 1'b0;
      base_vertex_r   <= 16'd0;
      row_stride_r    <= 16'd0;
      column_stride_r <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QUAD_COLUMNS:  quad_columns_r  <= cfg_data[7:0];
        CFG_QUAD_ROWS:     quad_rows_r     <= cfg_data[7:0];
        CFG_TAP_FIRST:     tap_first_r     <= cfg_data[0];
        CFG_TAP_LAST:      tap_last_r      <= cfg_data[0];
        CFG_BASE_VERTEX:   base_vertex_r   <= cfg_data;
        CFG_ROW_STRIDE:    row_stride_r    <= cfg_data;
        CFG_COLUMN_STRIDE: column_stride_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero strides fall back to one column and one full row of vertices
  assign cols_plus_one = {1'b0, quad_columns_r} + 9'd1;

  always_comb begin
    cfg.quad_columns = quad_columns_r;
    cfg.quad_rows    = quad_rows_r;
    cfg.tap_first    = tap_first_r;
    cfg.tap_last     = tap_last_r;
    cfg.base_vertex  = base_vertex_r;
    cfg.row_step     = (row_stride_r != 16'd0) ? row_stride_r : {7'd0, cols_plus_one};
    cfg.col_step     = (column_stride_r != 16'd0) ? column_stride_r : 16'd1;
  end

endmodule

// ===== rtl/core/tms_out_stage.sv =====
// Result register that parts the sequencer from the receiver.
module tms_out_stage (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [15:0] vertex_in,
  input  logic        end_in,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_vertex_index,
  output logic        out_strip_end
);

  logic        valid_r;
  logic [15:0] vertex_r;
  logic        end_r;

  // Room for a new item when empty or when the held item leaves now
  assign can_load = !valid_r || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      vertex_r <= vertex_in;
      end_r    <= end_in;
    end
  end

  assign out_valid        = valid_r;
  assign out_vertex_index = vertex_r;
  assign out_strip_end    = end_r;

endmodule
